/* design/lbp_pkg.sv */
// Shared types, register indexes and reset values for the breathing-LED PWM core.
// Used by lbp_cfg_regs, lbp_tick_engine and led_breathing_pwm_core; no dependencies.
package lbp_pkg;

	// Input word: one tick
	typedef struct packed {
		logic operation;
		logic enable;
	} req_t;

	// Output word: pin level and duty after the tick
	typedef struct packed {
		logic       led_level;
		logic [7:0] duty_now;
	} rsp_t;

	// Configuration register file contents
	typedef struct packed {
		logic [7:0] pwm_top;
		logic [9:0] hold_off_end;
		logic [9:0] rise_end;
		logic [9:0] hold_on_end;
		logic [9:0] fall_end;
		logic [7:0] duty_max;
		logic [7:0] duty_full;
	} cfg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 10;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PWM_TOP      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_OFF_END = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RISE_END     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_ON_END  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FALL_END     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MAX     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_FULL    = 3'd6;

	// Register reset values
	localparam logic [7:0] RST_PWM_TOP      = 8'd100;
	localparam logic [9:0] RST_HOLD_OFF_END = 10'd10;
	localparam logic [9:0] RST_RISE_END     = 10'd200;
	localparam logic [9:0] RST_HOLD_ON_END  = 10'd210;
	localparam logic [9:0] RST_FALL_END     = 10'd410;
	localparam logic [7:0] RST_DUTY_MAX     = 8'd100;
	localparam logic [7:0] RST_DUTY_FULL    = 8'd101;

	// Tick kinds
	localparam logic OP_FAST = 1'b0;
	localparam logic OP_SLOW = 1'b1;

endpackage

/* design/lbp_cfg_regs.sv */
// Configuration register file for the breathing-LED PWM core.
// Depends on lbp_pkg for the register indexes, reset values and cfg_t.
module lbp_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lbp_pkg::cfg_t                   cfg
);

	lbp_pkg::cfg_t cfg_q;

	// Always take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Store the written word; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_top      <= lbp_pkg::RST_PWM_TOP;
			cfg_q.hold_off_end <= lbp_pkg::RST_HOLD_OFF_END;
			cfg_q.rise_end     <= lbp_pkg::RST_RISE_END;
			cfg_q.hold_on_end  <= lbp_pkg::RST_HOLD_ON_END;
			cfg_q.fall_end     <= lbp_pkg::RST_FALL_END;
			cfg_q.duty_max     <= lbp_pkg::RST_DUTY_MAX;
			cfg_q.duty_full    <= lbp_pkg::RST_DUTY_FULL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lbp_pkg::REG_PWM_TOP:      cfg_q.pwm_top      <= cfg_data[7:0];
				lbp_pkg::REG_HOLD_OFF_END: cfg_q.hold_off_end <= cfg_data[9:0];
				lbp_pkg::REG_RISE_END:     cfg_q.rise_end     <= cfg_data[9:0];
				lbp_pkg::REG_HOLD_ON_END:  cfg_q.hold_on_end  <= cfg_data[9:0];
				lbp_pkg::REG_FALL_END:     cfg_q.fall_end     <= cfg_data[9:0];
				lbp_pkg::REG_DUTY_MAX:     cfg_q.duty_max     <= cfg_data[7:0];
				lbp_pkg::REG_DUTY_FULL:    cfg_q.duty_full    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* design/lbp_tick_engine.sv */
// Tick engine: input register, counter/duty state update and result register.
// Depends on lbp_pkg for req_t, rsp_t, cfg_t and the tick kinds.
module lbp_tick_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  lbp_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_ready,
	input  lbp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lbp_pkg::rsp_t rsp
);

	logic          req_valid_s1;
	lbp_pkg::req_t req_s1;
	logic          rsp_valid_s2;
	lbp_pkg::rsp_t rsp_s2;

	logic [7:0] pwm_q;
	logic [9:0] phase_q;
	logic [7:0] duty_q;
	logic       pin_q;

	logic [7:0] pwm_nxt;
	logic [9:0] phase_nxt;
	logic [7:0] duty_nxt;
	logic       pin_nxt;
	logic [8:0]  pwm_inc;
	logic [10:0] phase_inc;
	logic        advance;

	// Move stage 1 into the result register when that register is free or drains
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// Compute the next counters, duty and pin from the word in stage 1
	always_comb begin
		pwm_nxt   = pwm_q;
		phase_nxt = phase_q;
		duty_nxt  = duty_q;
		pin_nxt   = pin_q;
		pwm_inc   = {1'b0, pwm_q} + 9'd1;
		phase_inc = {1'b0, phase_q} + 11'd1;
		if (!req_s1.enable) begin
			pin_nxt = 1'b1;
		end else if (req_s1.operation == lbp_pkg::OP_FAST) begin
			pin_nxt = (pwm_q >= duty_q);
			pwm_nxt = (pwm_inc > {1'b0, cfg.pwm_top}) ? 8'd0 : pwm_inc[7:0];
		end else begin
			if (phase_q < cfg.hold_off_end) begin
				duty_nxt = 8'd0;
			end else if (phase_q < cfg.rise_end) begin
				if (!phase_q[0] && (duty_q < cfg.duty_max)) begin
					duty_nxt = duty_q + 8'd1;
				end
			end else if (phase_q < cfg.hold_on_end) begin
				duty_nxt = cfg.duty_full;
			end else if (phase_q < cfg.fall_end) begin
				if (!phase_q[0] && (duty_q != 8'd0)) begin
					duty_nxt = duty_q - 8'd1;
				end
			end
			phase_nxt = (phase_inc > {1'b0, cfg.fall_end}) ? 10'd0 : phase_inc[9:0];
		end
	end

	// Hold control state: stage valids, counters, duty and pin latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
			pwm_q        <= 8'd0;
			phase_q      <= 10'd0;
			duty_q       <= 8'd0;
			pin_q        <= 1'b1;
		end else begin
			if (req_ready) begin
				req_valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_s2 <= 1'b1;
				pwm_q        <= pwm_nxt;
				phase_q      <= phase_nxt;
				duty_q       <= duty_nxt;
				pin_q        <= pin_nxt;
			end else if (rsp_ready) begin
				rsp_valid_s2 <= 1'b0;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2.led_level <= pin_nxt;
			rsp_s2.duty_now  <= duty_nxt;
		end
	end

`ifndef SYNTHESIS
	// A disabled tick reports a dark pin
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !req_s1.enable |=> rsp_s2.led_level)
		else $error("disabled tick did not report a dark pin");

	// A disabled tick leaves both counters and the duty alone
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !req_s1.enable |=> $stable(pwm_q) && $stable(phase_q) && $stable(duty_q))
		else $error("disabled tick changed state");

	// A fast tick never moves the duty or the phase
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_s1.operation == lbp_pkg::OP_FAST) |=> $stable(duty_q) && $stable(phase_q))
		else $error("fast tick changed duty or phase");

	// The reported duty tracks the duty register
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s2 |-> (rsp_s2.duty_now == duty_q))
		else $error("reported duty differs from duty state");

	// Input stalls only when both stages are full and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> req_valid_s1 && rsp_valid_s2 && !rsp_ready)
		else $error("input stalled without a full pipeline");
`endif

endmodule

/* design/led_breathing_pwm_core.sv */
// Breathing-LED PWM core, top level: configuration registers plus tick engine.
// Depends on lbp_pkg, lbp_cfg_regs and lbp_tick_engine.
//
// Each input word is one tick: a fast tick steps the PWM counter and sets the
// active-low pin (high while the counter is at or above the duty), a slow tick
// steps the phase counter through dark hold, rising ramp, full-on hold and
// falling ramp and shapes the duty. With enable low the state holds and the pin
// reads high. Every word yields one result word with the pin level and duty.
// The block takes one word per clock. An accepted word is held in the input
// register and passes through the combinational state update into the result
// register, from which its result word is offered. Input stalls only while both
// registers are full and the result is not taken. Registers are written through
// the cfg port and take effect on the next tick; write them only while the core
// is idle.
module led_breathing_pwm_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  lbp_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output lbp_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lbp_pkg::cfg_t cfg;

	// Register file
	lbp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Tick pipeline
	lbp_tick_engine u_tick_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
